/* rtl/hex_lattice_snap_macros.svh */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: assertion macros
// Short forms for the concurrent checks, sampled on clk and off in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_LATTICE_SNAP_MACROS_SVH
`define HEX_LATTICE_SNAP_MACROS_SVH

// Implication check: when the antecedent holds, the consequent must follow.
`define HLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Invariant check: the expression holds at every clock edge out of reset.
`define HLS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

/* rtl/hls_pkg.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: shared package
// Widths, constants, beat types and neighbor codes of the snap pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hls_pkg;

  // Field widths.
  localparam int PITCH_W   = 16;
  localparam int COORD_W   = 24;
  localparam int SQRT3_W   = 32;
  localparam int PYQ_W     = PITCH_W + SQRT3_W;

  // sqrt(3)/2 as unsigned Q0.32.
  localparam logic [SQRT3_W-1:0] SQRT3_2_Q32 = 32'd3719550787;

  // Pitch register reset value and floor.
  localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd12800;
  localparam logic [PITCH_W-1:0] PITCH_MIN   = 16'd256;
  localparam logic [PYQ_W-1:0]   PYQ_RESET   = 48'd12800 * 48'd3719550787;

  // Divider geometry: quotient bits, numerator and divisor widths.
  localparam int QUO_W  = 17;
  localparam int NUMX_W = 27;
  localparam int DENX_W = PITCH_W + 1;
  localparam int NUMY_W = 58;
  localparam int DENY_W = PYQ_W + 1;

  // Site coordinates: x in half-LSB units, y in 2^-32 LSB units.
  localparam int CX_W   = 27;
  localparam int CY_W   = 58;

  // Distance compare operands.
  localparam int DM_W   = 18;
  localparam int EM_W   = 26;
  localparam int SQD_W  = 2 * DM_W;
  localparam int SQE_W  = 2 * EM_W;
  localparam int DIST_W = 55;

  // Rounded magnitude width and saturation limits.
  localparam int MAG_W = 32;
  localparam logic [MAG_W-1:0] SAT_POS = 32'h007F_FFFF;
  localparam logic [MAG_W-1:0] SAT_NEG = 32'h0080_0000;

  // Pipeline depth: input and numerator stages, divider, neighbor stages.
  localparam int NEAR_LAT    = 10;
  localparam int HLS_LATENCY = 2 + QUO_W + NEAR_LAT;

  // Input beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } hls_in_t;

  // Result beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] site_x;
    logic signed [COORD_W-1:0] site_y;
  } hls_out_t;

  // Rounded index magnitudes with the original point, leaving the divider.
  typedef struct packed {
    logic [QUO_W-1:0]          nxm;
    logic [QUO_W-1:0]          nym;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } hls_quo_t;

  // Neighbor codes in compare order.
  typedef enum logic [1:0] {
    NB_LEFT  = 2'd0,
    NB_DOWN  = 2'd1,
    NB_UP    = 2'd2,
    NB_RIGHT = 2'd3
  } hls_nb_t;

endpackage

/* rtl/hls_div_pipe.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: pipelined restoring divider
// One quotient bit per register stage; the caller must hold the divisor
// steady while beats are in flight, which this block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hls_div_pipe import hls_pkg::*; #(
  parameter int NW = NUMX_W,
  parameter int DW = DENX_W,
  parameter int QW = QUO_W
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;

    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] rem_ext;
    logic          take;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // Trial subtract of the divisor shifted to this quotient bit.
    assign trial   = CW'(den) << B;
    assign rem_ext = CW'(rem_in);
    assign take    = (rem_ext >= trial);
    assign rem_nxt = take ? NW'(rem_ext - trial) : rem_in;
    assign quo_nxt = take ? (quo_in | (QW'(1) << B)) : quo_in;

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      quo_r[i] <= quo_nxt;
    end
  end

  assign quo = quo_r[QW-1];

endmodule

/* rtl/hls_near.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: neighbor choice and output rounding
// Turns rounded indices into a site, picks the closest of four neighbors
// when the index sum is odd, then rounds and saturates the site.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hls_near import hls_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  hls_quo_t           in_beat,
  input  logic [PITCH_W-1:0] pitch,
  input  logic [PYQ_W-1:0]   pyq,
  output logic               out_valid,
  output hls_out_t           out_data
);

  // Magnitude of an x offset, in half-LSB units.
  function automatic logic [DM_W-1:0] mag_x(input logic signed [CX_W:0] v);
    logic [CX_W:0] a;
    a = v[CX_W] ? (~v + 1'b1) : v;
    return a[DM_W-1:0];
  endfunction

  // Magnitude of a y offset, truncated to 2^-8 LSB units.
  function automatic logic [EM_W-1:0] mag_y(input logic signed [CY_W:0] v);
    logic [CY_W:0] a;
    a = v[CY_W] ? (~v + 1'b1) : v;
    return a[EM_W+23:24];
  endfunction

  // Saturate a signed magnitude to the 24-bit coordinate range.
  function automatic logic [COORD_W-1:0] pack_sat(input logic neg,
                                                  input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] lim;
    if (!neg) begin
      lim = (m > SAT_POS) ? SAT_POS : m;
    end else begin
      lim = (m > SAT_NEG) ? SAT_NEG : m;
      lim = ~lim + 1'b1;
    end
    return lim[COORD_W-1:0];
  endfunction

  // Valid bits, one per stage.
  logic [NEAR_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NEAR_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NEAR_LAT-1];

  // Stage 1: signed indices times the row and column steps.
  logic signed [QUO_W:0]               nx_s, ny_s;
  logic signed [QUO_W+DENX_W:0]        cx_full;
  logic signed [QUO_W+DENY_W:0]        cy_full;
  logic signed [CX_W-1:0]              cx1_r;
  logic signed [CY_W-1:0]              cy1_r;
  logic signed [COORD_W-1:0]           x1_r, y1_r;
  logic                                odd1_r;

  always_comb begin
    nx_s = in_beat.x[COORD_W-1] ? -$signed({1'b0, in_beat.nxm})
                                :  $signed({1'b0, in_beat.nxm});
    ny_s = in_beat.y[COORD_W-1] ? -$signed({1'b0, in_beat.nym})
                                :  $signed({1'b0, in_beat.nym});
    cx_full = nx_s * $signed({1'b0, pitch});
    cy_full = ny_s * $signed({1'b0, pyq});
  end

  always_ff @(posedge clk) begin
    cx1_r  <= cx_full[CX_W-1:0];
    cy1_r  <= cy_full[CY_W-1:0];
    x1_r   <= in_beat.x;
    y1_r   <= in_beat.y;
    odd1_r <= in_beat.nxm[0] ^ in_beat.nym[0];
  end

  // Stage 2: residual of the point against the site.
  logic signed [CX_W-1:0] x2, rx_nxt, rx2_r, cx2_r;
  logic signed [CY_W-1:0] y32, ry_nxt, ry2_r, cy2_r;
  logic                   odd2_r;

  always_comb begin
    x2     = {{(CX_W-COORD_W-1){x1_r[COORD_W-1]}}, x1_r, 1'b0};
    y32    = {{(CY_W-COORD_W-32){y1_r[COORD_W-1]}}, y1_r, 32'b0};
    rx_nxt = x2 - cx1_r;
    ry_nxt = y32 - cy1_r;
  end

  always_ff @(posedge clk) begin
    rx2_r  <= rx_nxt;
    ry2_r  <= ry_nxt;
    cx2_r  <= cx1_r;
    cy2_r  <= cy1_r;
    odd2_r <= odd1_r;
  end

  // Stage 3: offset magnitudes toward each neighbor.
  logic signed [CX_W:0]   rxe, pxe;
  logic signed [CY_W:0]   rye, pye;
  logic [DM_W-1:0]        dm3_r [3];
  logic [EM_W-1:0]        em3_r [3];
  logic signed [CX_W-1:0] cx3_r;
  logic signed [CY_W-1:0] cy3_r;
  logic                   odd3_r;

  always_comb begin
    rxe = {rx2_r[CX_W-1], rx2_r};
    pxe = $signed({{(CX_W+1-PITCH_W){1'b0}}, pitch});
    rye = {ry2_r[CY_W-1], ry2_r};
    pye = $signed({{(CY_W+1-PYQ_W){1'b0}}, pyq});
  end

  always_ff @(posedge clk) begin
    dm3_r[0] <= mag_x(rxe + pxe);
    dm3_r[1] <= mag_x(rxe);
    dm3_r[2] <= mag_x(rxe - pxe);
    em3_r[0] <= mag_y(rye);
    em3_r[1] <= mag_y(rye + pye);
    em3_r[2] <= mag_y(rye - pye);
    cx3_r    <= cx2_r;
    cy3_r    <= cy2_r;
    odd3_r   <= odd2_r;
  end

  // Stage 4: squares.
  logic [SQD_W-1:0]       dsq4_r [3];
  logic [SQE_W-1:0]       esq4_r [3];
  logic signed [CX_W-1:0] cx4_r;
  logic signed [CY_W-1:0] cy4_r;
  logic                   odd4_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dsq4_r[j] <= SQD_W'(dm3_r[j]) * SQD_W'(dm3_r[j]);
      esq4_r[j] <= SQE_W'(em3_r[j]) * SQE_W'(em3_r[j]);
    end
    cx4_r  <= cx3_r;
    cy4_r  <= cy3_r;
    odd4_r <= odd3_r;
  end

  // Stage 5: squared distance to each neighbor.
  logic [DIST_W-1:0]      dist5_r [4];
  logic signed [CX_W-1:0] cx5_r;
  logic signed [CY_W-1:0] cy5_r;
  logic                   odd5_r;

  always_ff @(posedge clk) begin
    dist5_r[0] <= DIST_W'({dsq4_r[0], 14'b0}) + DIST_W'(esq4_r[0]);
    dist5_r[1] <= DIST_W'({dsq4_r[1], 14'b0}) + DIST_W'(esq4_r[1]);
    dist5_r[2] <= DIST_W'({dsq4_r[1], 14'b0}) + DIST_W'(esq4_r[2]);
    dist5_r[3] <= DIST_W'({dsq4_r[2], 14'b0}) + DIST_W'(esq4_r[0]);
    cx5_r      <= cx4_r;
    cy5_r      <= cy4_r;
    odd5_r     <= odd4_r;
  end

  // Stage 6: pairwise minimum; the earlier neighbor wins a tie.
  logic [DIST_W-1:0]      b01_r, b23_r;
  hls_nb_t                k01_r, k23_r;
  logic signed [CX_W-1:0] cx6_r;
  logic signed [CY_W-1:0] cy6_r;
  logic                   odd6_r;

  always_ff @(posedge clk) begin
    if (dist5_r[1] < dist5_r[0]) begin
      b01_r <= dist5_r[1];
      k01_r <= NB_DOWN;
    end else begin
      b01_r <= dist5_r[0];
      k01_r <= NB_LEFT;
    end
    if (dist5_r[3] < dist5_r[2]) begin
      b23_r <= dist5_r[3];
      k23_r <= NB_RIGHT;
    end else begin
      b23_r <= dist5_r[2];
      k23_r <= NB_UP;
    end
    cx6_r  <= cx5_r;
    cy6_r  <= cy5_r;
    odd6_r <= odd5_r;
  end

  // Stage 7: final choice.
  hls_nb_t                kf7_r;
  logic signed [CX_W-1:0] cx7_r;
  logic signed [CY_W-1:0] cy7_r;
  logic                   odd7_r;

  always_ff @(posedge clk) begin
    kf7_r  <= (b23_r < b01_r) ? k23_r : k01_r;
    cx7_r  <= cx6_r;
    cy7_r  <= cy6_r;
    odd7_r <= odd6_r;
  end

  // Stage 8: move to the chosen neighbor when the index sum is odd.
  logic signed [CX_W:0] sx_nxt, sx8_r, cxe;
  logic signed [CY_W:0] sy_nxt, sy8_r, cye;

  always_comb begin
    cxe    = {cx7_r[CX_W-1], cx7_r};
    cye    = {cy7_r[CY_W-1], cy7_r};
    sx_nxt = cxe;
    sy_nxt = cye;
    if (odd7_r) begin
      case (kf7_r)
        NB_LEFT:  sx_nxt = cxe - pxe;
        NB_RIGHT: sx_nxt = cxe + pxe;
        NB_DOWN:  sy_nxt = cye - pye;
        NB_UP:    sy_nxt = cye + pye;
        default:  sx_nxt = cxe;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sx8_r <= sx_nxt;
    sy8_r <= sy_nxt;
  end

  // Stage 9: round magnitudes to the nearest LSB, half away from zero.
  logic [CX_W:0]      sxa;
  logic [CY_W:0]      sya;
  logic [CY_W:0]      sy_rnd;
  logic               negx9_r, negy9_r;
  logic [MAG_W-1:0]   magx9_r, magy9_r;

  always_comb begin
    sxa    = sx8_r[CX_W] ? (~sx8_r + 1'b1) : sx8_r;
    sya    = sy8_r[CY_W] ? (~sy8_r + 1'b1) : sy8_r;
    sy_rnd = sya + (CY_W+1)'(33'h0_8000_0000);
  end

  always_ff @(posedge clk) begin
    negx9_r <= sx8_r[CX_W];
    negy9_r <= sy8_r[CY_W];
    magx9_r <= MAG_W'((MAG_W'(sxa) + 1'b1) >> 1);
    magy9_r <= MAG_W'(sy_rnd >> 32);
  end

  // Stage 10: saturate into the result register.
  hls_out_t out_r;

  always_ff @(posedge clk) begin
    out_r.site_x <= pack_sat(negx9_r, magx9_r);
    out_r.site_y <= pack_sat(negy9_r, magy9_r);
  end

  assign out_data = out_r;

endmodule

/* rtl/hex_lattice_snap.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: top level
// Snaps a Q15.8 point to the nearest site of a hexagonal lattice of
// programmable pitch, one point per clock.
//
//   channel   signals                      direction   beat rule
//   input     start, busy, in_data         in          start && !busy
//   result    out_valid, out_data          out         out_valid, one cycle
//   config    cfg_we, cfg_wdata            in          cfg_we
//
// An accepted point passes through two stages that form the numerators,
// 17 divider stages that give one index bit each, and ten stages that
// choose the neighbor, round and saturate. A new point may enter every
// cycle and busy stays low. Reset is synchronous; it clears the valid
// bits and loads the pitch with its default. Results cannot be held off,
// so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_lattice_snap import hls_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hls_in_t            in_data,
  input  logic               cfg_we,
  input  logic [PITCH_W-1:0] cfg_wdata,
  output logic               out_valid,
  output hls_out_t           out_data
);

  // Pitch register.
  logic [PITCH_W-1:0] pitch_r;
  logic [PITCH_W-1:0] p_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
    end else if (cfg_we) begin
      pitch_r <= cfg_wdata;
    end
  end

  // Pitches below the floor act as the floor.
  assign p_eff = (pitch_r < PITCH_MIN) ? PITCH_MIN : pitch_r;

  // Row step p*sqrt(3)/2, kept in 2^-32 LSB units.
  logic [PYQ_W-1:0] pyq_r, pyq_nxt;

  assign pyq_nxt = PYQ_W'(p_eff) * PYQ_W'(SQRT3_2_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pyq_r <= PYQ_RESET;
    end else begin
      pyq_r <= pyq_nxt;
    end
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: input register.
  logic                      v_s1_r;
  logic signed [COORD_W-1:0] x_s1_r, y_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
    end else begin
      v_s1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x_s1_r <= in_data.point_x;
    y_s1_r <= in_data.point_y;
  end

  // Stage 2: rounding numerators from the coordinate magnitudes.
  logic [COORD_W-1:0]        ax, ay;
  logic [NUMX_W-1:0]         numx_nxt, numx_r;
  logic [NUMY_W-1:0]         numy_nxt, numy_r;
  logic                      v_s2_r;
  logic signed [COORD_W-1:0] x_s2_r, y_s2_r;

  always_comb begin
    ax       = x_s1_r[COORD_W-1] ? (~x_s1_r + 1'b1) : x_s1_r;
    ay       = y_s1_r[COORD_W-1] ? (~y_s1_r + 1'b1) : y_s1_r;
    numx_nxt = NUMX_W'({ax, 2'b00}) + NUMX_W'(p_eff);
    numy_nxt = NUMY_W'({ay, 33'b0}) + NUMY_W'(pyq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s2_r <= 1'b0;
    end else begin
      v_s2_r <= v_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    numx_r <= numx_nxt;
    numy_r <= numy_nxt;
    x_s2_r <= x_s1_r;
    y_s2_r <= y_s1_r;
  end

  // Index dividers: nx = num / 2p, ny = num / 2py.
  logic [DENX_W-1:0] denx;
  logic [DENY_W-1:0] deny;
  logic [QUO_W-1:0]  nxm, nym;

  assign denx = {p_eff, 1'b0};
  assign deny = {pyq_r, 1'b0};

  hls_div_pipe #(
    .NW (NUMX_W),
    .DW (DENX_W),
    .QW (QUO_W)
  ) u_divx (
    .clk (clk),
    .num (numx_r),
    .den (denx),
    .quo (nxm)
  );

  hls_div_pipe #(
    .NW (NUMY_W),
    .DW (DENY_W),
    .QW (QUO_W)
  ) u_divy (
    .clk (clk),
    .num (numy_r),
    .den (deny),
    .quo (nym)
  );

  // Valid bits and the point travel beside the dividers.
  logic [QUO_W-1:0]          dl_v_r;
  logic signed [COORD_W-1:0] dl_x_r [QUO_W];
  logic signed [COORD_W-1:0] dl_y_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_v_r <= '0;
    end else begin
      dl_v_r <= {dl_v_r[QUO_W-2:0], v_s2_r};
    end
  end

  always_ff @(posedge clk) begin
    dl_x_r[0] <= x_s2_r;
    dl_y_r[0] <= y_s2_r;
    for (int i = 1; i < QUO_W; i++) begin
      dl_x_r[i] <= dl_x_r[i-1];
      dl_y_r[i] <= dl_y_r[i-1];
    end
  end

  // Neighbor choice and output rounding.
  hls_quo_t quo_beat;

  assign quo_beat.nxm = nxm;
  assign quo_beat.nym = nym;
  assign quo_beat.x   = dl_x_r[QUO_W-1];
  assign quo_beat.y   = dl_y_r[QUO_W-1];

  hls_near u_near (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dl_v_r[QUO_W-1]),
    .in_beat   (quo_beat),
    .pitch     (p_eff),
    .pyq       (pyq_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/hls_checker.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: port checker
// Watches the top level's ports for the fixed latency and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hex_lattice_snap_macros.svh"

module hls_checker import hls_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Every accepted beat yields a result after the fixed latency.
  `HLS_ASSERT_IMPL(a_lat_fwd, start && !busy, ##HLS_LATENCY out_valid, "result beat missing")

  // Every result beat traces back to an accepted beat.
  `HLS_ASSERT_IMPL(a_lat_back, out_valid, $past(start && !busy, HLS_LATENCY), "stray result beat")

  // The pipeline takes a beat in every cycle.
  `HLS_ASSERT_ALWAYS(a_no_busy, !busy, "busy raised")

  // No result right after reset.
  `HLS_ASSERT_IMPL(a_rst_quiet, $rose(rst_n), !out_valid, "result beat out of reset")

endmodule

bind hex_lattice_snap hls_checker u_hls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

/* tb/hex_lattice_snap_tb.sv */
// ----------------------------------------------------------------------------
// Hexagonal lattice snap: testbench
// Drives points through a directed table and then random bursts, predicts
// the snapped site in the testbench, and checks every result beat in order
// against the queue of predicted sites. The pitch is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_lattice_snap_tb;
  import hls_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  hls_in_t            in_data = '0;
  logic               cfg_we = 1'b0;
  logic [PITCH_W-1:0] cfg_wdata = '0;
  logic               out_valid;
  hls_out_t           out_data;

  hex_lattice_snap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Directed stimulus row: the point and, where known, the expected site.
  typedef struct {
    logic [PITCH_W-1:0] pitch;
    hls_in_t            pt;
    bit                 has_exp;
    hls_out_t           site;
  } snap_row_t;

  logic [PITCH_W-1:0] pitch_reg = PITCH_RESET;
  hls_out_t           site_queue[$];
  int                 fail_count = 0;
  int                 idle_cycles = 0;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [COORD_W-1:0] round_sat(bit neg, longint unsigned mag);
    if (!neg) begin
      if (mag > 64'h7F_FFFF) mag = 64'h7F_FFFF;
      return mag[COORD_W-1:0];
    end
    if (mag > 64'h80_0000) mag = 64'h80_0000;
    return COORD_W'(25'h100_0000 - mag[24:0]);
  endfunction

  // Nearest lattice site of one point at the current pitch.
  function automatic hls_out_t snap_site(hls_in_t pt, logic [PITCH_W-1:0] pr);
    longint x, y, nx, ny, cx2, cyq, sx2, syq, rx2, ryq, dx2, dyq, di, dj;
    longint unsigned p, pyq, nxm, nym, d, e, dsum, best;
    int bk;
    hls_out_t r;
    x = longint'(pt.point_x);
    y = longint'(pt.point_y);
    p = (pr < PITCH_MIN) ? 64'(PITCH_MIN) : 64'(pr);
    pyq = p * 64'(SQRT3_2_Q32);
    nxm = (4 * abs64(x) + p) / (2 * p);
    nym = ((abs64(y) << 33) + pyq) / (2 * pyq);
    nx = (x < 0) ? -longint'(nxm) : longint'(nxm);
    ny = (y < 0) ? -longint'(nym) : longint'(nym);
    cx2 = nx * longint'(p);
    cyq = ny * longint'(pyq);
    sx2 = cx2;
    syq = cyq;
    if (((nxm + nym) & 1) != 0) begin
      rx2 = 2 * x - cx2;
      ryq = y * 64'sd4294967296 - cyq;
      best = 0;
      bk = 0;
      for (int k = 0; k < 4; k++) begin
        di = (k == NB_LEFT) ? -1 : (k == NB_RIGHT) ? 1 : 0;
        dj = (k == NB_DOWN) ? -1 : (k == NB_UP) ? 1 : 0;
        dx2 = rx2 - di * longint'(p);
        dyq = ryq - dj * longint'(pyq);
        d = abs64(dx2) * 128;
        e = abs64(dyq) >> 24;
        dsum = d * d + e * e;
        if (k == 0 || dsum < best) begin
          best = dsum;
          bk = k;
        end
      end
      di = (bk == NB_LEFT) ? -1 : (bk == NB_RIGHT) ? 1 : 0;
      dj = (bk == NB_DOWN) ? -1 : (bk == NB_UP) ? 1 : 0;
      sx2 = cx2 + di * longint'(p);
      syq = cyq + dj * longint'(pyq);
    end
    r.site_x = round_sat(sx2 < 0, (abs64(sx2) + 1) >> 1);
    r.site_y = round_sat(syq < 0, (abs64(syq) + 64'h8000_0000) >> 32);
    return r;
  endfunction

  // Result checker and idle watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (site_queue.size() == 0) begin
          $error("result beat with no point waiting: %0d %0d",
                 out_data.site_x, out_data.site_y);
          fail_count = fail_count + 1;
        end else begin
          hls_out_t want;
          want = site_queue.pop_front();
          if (out_data.site_x !== want.site_x) begin
            $error("site_x expected %0d actual %0d", want.site_x, out_data.site_x);
            fail_count = fail_count + 1;
          end
          if (out_data.site_y !== want.site_y) begin
            $error("site_y expected %0d actual %0d", want.site_y, out_data.site_y);
            fail_count = fail_count + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one point at the falling edge and hold it until accepted.
  task automatic send_point(hls_in_t pt, hls_out_t want);
    @(negedge clk);
    start <= 1'b1;
    in_data <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    site_queue = {site_queue, want};
  endtask

  task automatic drop_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Pitch write while the pipeline is drained.
  task automatic write_pitch(logic [PITCH_W-1:0] v);
    drop_start();
    while (site_queue.size() != 0) @(negedge clk);
    repeat (HLS_LATENCY + 2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    pitch_reg = v;
  endtask

  function automatic hls_in_t rand_point(int mode);
    hls_in_t pt;
    case (mode)
      0: begin
        pt.point_x = COORD_W'($urandom);
        pt.point_y = COORD_W'($urandom);
      end
      1: begin
        pt.point_x = COORD_W'($signed($urandom_range(0, 8000)) - 4000);
        pt.point_y = COORD_W'($signed($urandom_range(0, 8000)) - 4000);
      end
      default: begin
        pt.point_x = COORD_W'($signed($urandom_range(0, 400000)) - 200000);
        pt.point_y = COORD_W'($signed($urandom_range(0, 400000)) - 200000);
      end
    endcase
    return pt;
  endfunction

  snap_row_t dir_rows[$];
  logic [PITCH_W-1:0] pitch_set[6] = '{16'd256, 16'd65535, 16'd0, 16'd100,
                                       16'd777, 16'd12800};

  initial begin
    snap_row_t row;
    hls_out_t want;
    int burst;

    // Directed table: after reset the zero point snaps to the origin.
    row = '{PITCH_RESET, '{24'sd0, 24'sd0}, 1'b1, '{24'sd0, 24'sd0}};
    dir_rows = {dir_rows, row};
    // Exact lattice site (p, 0) at the default pitch.
    row = '{PITCH_RESET, '{24'sd12800, 24'sd0}, 1'b1, '{24'sd12800, 24'sd0}};
    dir_rows = {dir_rows, row};
    // Corners at the smallest and the largest pitch.
    row = '{16'd0, '{24'h7FFFFF, 24'h7FFFFF}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd0, '{24'h800000, 24'h800000}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd65535, '{24'h7FFFFF, 24'h800000}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd65535, '{24'h800000, 24'h7FFFFF}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd65535, '{24'sd0, 24'sd0}, 1'b1, '{24'sd0, 24'sd0}};
    dir_rows = {dir_rows, row};
    // Half-pitch points, odd-sum cells and tie edges.
    row = '{16'd256, '{24'sd64, 24'sd0}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd256, '{-24'sd64, 24'sd111}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd256, '{24'sd128, 24'sd111}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd256, '{-24'sd1, -24'sd1}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd12800, '{24'sd3200, 24'sd5542}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd12800, '{-24'sd6400, -24'sd11085}, 1'b0, '0};
    dir_rows = {dir_rows, row};
    row = '{16'd12800, '{24'sd9600, -24'sd2771}, 1'b0, '0};
    dir_rows = {dir_rows, row};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].pitch != pitch_reg) write_pitch(dir_rows[i].pitch);
      want = dir_rows[i].has_exp ? dir_rows[i].site
                                 : snap_site(dir_rows[i].pt, pitch_reg);
      send_point(dir_rows[i].pt, want);
    end

    // Random bursts over several pitch settings, extremes included.
    for (int ph = 0; ph < 7; ph++) begin
      write_pitch(ph < 6 ? pitch_set[ph] : 16'($urandom_range(0, 65535)));
      for (int n = 0; n < RANDOM_ITEMS / 7; ) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst; b++) begin
          hls_in_t pt;
          pt = rand_point($urandom_range(0, 2));
          send_point(pt, snap_site(pt, pitch_reg));
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          drop_start();
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
      end
    end

    drop_start();
    while (site_queue.size() != 0) @(negedge clk);
    repeat (HLS_LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && site_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/hls_pkg.sv
rtl/hls_div_pipe.sv
rtl/hls_near.sv
rtl/hex_lattice_snap.sv
rtl/hls_checker.sv
tb/hex_lattice_snap_tb.sv
